// ===== rtl/core/ffr_pkg.sv =====
// ffr_pkg: types and constants shared by the fixed frame receiver modules
// no dependencies

`default_nettype none

package ffr_pkg;

    // frame layout
    localparam int FRAME_LENGTH = 14;
    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_IDLE       = 4'd0;
    localparam logic [POS_W-1:0] POS_ADDRESS    = 4'd1;
    localparam logic [POS_W-1:0] POS_LENGTH     = 4'd2;
    localparam logic [POS_W-1:0] POS_WORD0      = 4'd3;
    localparam logic [POS_W-1:0] POS_WORD0_LAST = 4'd6;
    localparam logic [POS_W-1:0] POS_WORD1      = 4'd7;
    localparam logic [POS_W-1:0] POS_WORD1_LAST = 4'd10;
    localparam logic [POS_W-1:0] POS_COMMAND    = 4'd11;
    localparam logic [POS_W-1:0] POS_FLAGS      = 4'd12;
    localparam logic [POS_W-1:0] POS_CHECKSUM   = POS_W'(FRAME_LENGTH - 1);

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAD_BYTE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDR   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LEN = 2'd2;

    localparam logic [7:0] RESET_HEAD_BYTE   = 8'd165;
    localparam logic [7:0] RESET_OWN_ADDR    = 8'd1;
    localparam logic [7:0] RESET_PAYLOAD_LEN = 8'd10;

    localparam int M_TDATA_W = 88;

    typedef enum logic [1:0] {
        FRAME_OK       = 2'd0,
        FRAME_BAD_ADDR = 2'd1,
        FRAME_BAD_LEN  = 2'd2,
        FRAME_BAD_SUM  = 2'd3
    } ffr_status_t;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] own_address;
        logic [7:0] payload_length;
    } ffr_cfg_t;

    typedef struct packed {
        logic        valid;
        ffr_status_t status;
        logic [31:0] track_error_bits;
        logic [31:0] target_speed_bits;
        logic [7:0]  state_command;
        logic [7:0]  flag_byte;
    } ffr_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffr_collect.sv =====
// ffr_collect: byte position tracking, field capture and checksum of one frame
// depends on ffr_pkg

`default_nettype none

module ffr_collect
    import ffr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        byte_fire,
    input  wire logic [7:0]  rx_byte,
    input  wire ffr_cfg_t    cfg,
    output ffr_result_t      res
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic             addr_ok_reg;
    logic             len_ok_reg;
    logic [31:0]      word0_reg;
    logic [31:0]      word1_reg;
    logic [7:0]       command_reg;
    logic [7:0]       flags_reg;
    logic [POS_W-1:0] lane_off;
    logic [1:0]       lane;
    logic             at_end;

    assign at_end = (pos_reg >= POS_CHECKSUM);

    always_comb begin
        lane_off = (pos_reg <= POS_WORD0_LAST) ? (pos_reg - POS_WORD0) : (pos_reg - POS_WORD1);
    end
    assign lane = lane_off[1:0];

    always_comb begin
        res          = '0;
        res.status   = FRAME_OK;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        if (pos_reg == POS_IDLE) begin
            if (rx_byte == cfg.head_byte) begin
                pos_next = POS_ADDRESS;
                sum_next = rx_byte;
            end
        end else if (at_end) begin
            res.valid = 1'b1;
            if (!addr_ok_reg) begin
                res.status = FRAME_BAD_ADDR;
            end else if (!len_ok_reg) begin
                res.status = FRAME_BAD_LEN;
            end else if (sum_reg != rx_byte) begin
                res.status = FRAME_BAD_SUM;
            end else begin
                res.status            = FRAME_OK;
                res.track_error_bits  = word0_reg;
                res.target_speed_bits = word1_reg;
                res.state_command     = command_reg;
                res.flag_byte         = flags_reg;
            end
            pos_next = POS_IDLE;
            sum_next = 8'd0;
        end else begin
            pos_next = pos_reg + 4'd1;
            sum_next = sum_reg + rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_IDLE;
            sum_reg <= 8'd0;
        end else if (byte_fire) begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // captured fields, written before every use within a frame
    always_ff @(posedge aclk) begin
        if (byte_fire && !at_end) begin
            if (pos_reg == POS_ADDRESS) begin
                addr_ok_reg <= (rx_byte == cfg.own_address);
            end
            if (pos_reg == POS_LENGTH) begin
                len_ok_reg <= (rx_byte == cfg.payload_length);
            end
            if (pos_reg >= POS_WORD0 && pos_reg <= POS_WORD0_LAST) begin
                word0_reg[lane*8 +: 8] <= rx_byte;
            end
            if (pos_reg >= POS_WORD1 && pos_reg <= POS_WORD1_LAST) begin
                word1_reg[lane*8 +: 8] <= rx_byte;
            end
            if (pos_reg == POS_COMMAND) begin
                command_reg <= rx_byte;
            end
            if (pos_reg == POS_FLAGS) begin
                flags_reg <= rx_byte;
            end
        end
    end

`ifndef ASSERT_OFF
    a_end_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_fire && res.valid) |=> (pos_reg == POS_IDLE && sum_reg == 8'd0))
        else $error("position not cleared after frame end");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_CHECKSUM)
        else $error("byte position beyond frame end");

    a_bad_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && res.status != FRAME_OK) |->
        (res.track_error_bits == 32'd0 && res.target_speed_bits == 32'd0 &&
         res.state_command == 8'd0 && res.flag_byte == 8'd0))
        else $error("fields not zero on failed frame");

    a_idle_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_fire && pos_reg == POS_IDLE && rx_byte != cfg.head_byte) |=>
        (pos_reg == POS_IDLE))
        else $error("left idle on a non-head byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/fixed_frame_receiver.sv =====
// fixed_frame_receiver: top level, stream ports, configuration registers, result register
// depends on ffr_pkg and ffr_collect
//
// channel  | dir | handshake           | payload
// s_       | in  | s_tvalid / s_tready | s_tdata: rx_byte
// m_       | out | m_tvalid / m_tready | m_tdata: status, two words, command, flags
// cfg_     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one byte per cycle while s_tready is high; the frame state updates in the cycle
// a byte is accepted, and the result of a checksum byte shows on m_ in the next cycle
// s_tready drops only while a result sits in the output register and m_tready is low
// aresetn clears frame position, checksum, output valid; resets configuration registers
// cfg_ready is always high

`default_nettype none

module fixed_frame_receiver
    import ffr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // [1:0] frame_status, [33:2]
                                                   // track_error_bits, [65:34]
                                                   // target_speed_bits, [73:66]
                                                   // state_command, [81:74] flag_byte
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    ffr_cfg_t    cfg_reg;
    ffr_result_t res;
    ffr_result_t out_reg;
    logic        m_valid_reg;
    logic        s_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.head_byte      <= RESET_HEAD_BYTE;
            cfg_reg.own_address    <= RESET_OWN_ADDR;
            cfg_reg.payload_length <= RESET_PAYLOAD_LEN;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HEAD_BYTE:   cfg_reg.head_byte      <= cfg_data;
                REG_OWN_ADDR:    cfg_reg.own_address    <= cfg_data;
                REG_PAYLOAD_LEN: cfg_reg.payload_length <= cfg_data;
                default: ;
            endcase
        end
    end

    ffr_collect u_collect (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (s_fire),
        .rx_byte   (s_tdata),
        .cfg       (cfg_reg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= res.valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, out_reg.flag_byte, out_reg.state_command,
                       out_reg.target_speed_bits, out_reg.track_error_bits,
                       out_reg.status};

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(out_reg)))
        else $error("pending result lost");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    a_result_from_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg)) |-> $past(s_fire))
        else $error("result appeared without an accepted byte");
`endif

endmodule

`default_nettype wire
